[hw/rtl/mm3_pkg.sv]
// ----------------------------------------------------------------------------
// mm3_pkg
// shared constants and types of the murmur3 x86_32 hash block
// ----------------------------------------------------------------------------
package mm3_pkg;

  localparam int WORD_W  = 32;
  localparam int BYTES_W = 3;

  // byte count of a full word
  localparam logic [BYTES_W-1:0] BYTES_PER_WORD = 3'd4;

  // block mixing constants
  localparam logic [WORD_W-1:0] MIX_C1   = 32'hcc9e2d51;
  localparam logic [WORD_W-1:0] MIX_C2   = 32'h1b873593;
  localparam logic [WORD_W-1:0] HASH_ADD = 32'he6546b64;

  // finalizer constants
  localparam logic [WORD_W-1:0] FMIX_C1 = 32'h85ebca6b;
  localparam logic [WORD_W-1:0] FMIX_C2 = 32'hc2b2ae35;

  // one classified, pre-mixed word on its way from front to back
  typedef struct packed {
    logic [WORD_W-1:0]  k;
    logic [BYTES_W-1:0] nbytes;
    logic               last;
  } item_t;

endpackage

[hw/rtl/mm3_fifo.sv]
// ----------------------------------------------------------------------------
// mm3_fifo
// small register queue; space is guaranteed by the writer's credit count
// ----------------------------------------------------------------------------
module mm3_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assign rd_data = mem[rd_ptr];
  assign empty   = (count == '0);

endmodule

[hw/rtl/mm3_front.sv]
// ----------------------------------------------------------------------------
// mm3_front
// classifies each word by byte count and runs the two-multiply word mix
// ----------------------------------------------------------------------------
module mm3_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,
  input  logic [mm3_pkg::WORD_W-1:0]   data_word,
  input  logic [mm3_pkg::BYTES_W-1:0]  valid_bytes,
  input  logic                         last,
  output logic                         item_valid,
  output mm3_pkg::item_t               item
);

  logic [mm3_pkg::BYTES_W-1:0] nb;
  logic [mm3_pkg::WORD_W-1:0]  mask;
  logic [mm3_pkg::WORD_W-1:0]  k1_next;
  logic [mm3_pkg::WORD_W-1:0]  k2_next;

  logic                        s1_valid;
  logic [mm3_pkg::WORD_W-1:0]  s1_k;
  logic [mm3_pkg::BYTES_W-1:0] s1_nbytes;
  logic                        s1_last;

  // clamp byte count and drop unused bytes
  always_comb begin
    nb = (valid_bytes > mm3_pkg::BYTES_PER_WORD) ? mm3_pkg::BYTES_PER_WORD : valid_bytes;
    unique case (nb)
      3'd0:    mask = 32'h0000_0000;
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
    k1_next = (data_word & mask) * mm3_pkg::MIX_C1;
  end

  // rotate left 15 then second multiply
  assign k2_next = {s1_k[16:0], s1_k[31:17]} * mm3_pkg::MIX_C2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      item_valid <= 1'b0;
    end else begin
      s1_valid   <= take;
      item_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_k        <= k1_next;
    s1_nbytes   <= nb;
    s1_last     <= last;
    item.k      <= k2_next;
    item.nbytes <= s1_nbytes;
    item.last   <= s1_last;
  end

endmodule

[hw/rtl/mm3_back.sv]
// ----------------------------------------------------------------------------
// mm3_back
// running hash update, byte count and pipelined fmix32 finalizer
// ----------------------------------------------------------------------------
module mm3_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [mm3_pkg::WORD_W-1:0]  seed,
  input  logic                        item_valid,
  input  mm3_pkg::item_t              item,
  input  logic                        out_space,
  output logic                        item_pop,
  output logic                        res_valid,
  output logic [mm3_pkg::WORD_W-1:0]  res_hash
);

  logic                       started;
  logic [mm3_pkg::WORD_W-1:0] running_hash;
  logic [mm3_pkg::WORD_W-1:0] byte_total;

  logic [mm3_pkg::WORD_W-1:0] base;
  logic [mm3_pkg::WORD_W-1:0] x;
  logic [mm3_pkg::WORD_W-1:0] r;
  logic [mm3_pkg::WORD_W-1:0] hash_next;
  logic [mm3_pkg::WORD_W-1:0] total_next;

  logic                       f0_valid;
  logic                       f1_valid;
  logic [mm3_pkg::WORD_W-1:0] f0;
  logic [mm3_pkg::WORD_W-1:0] f1;
  logic [mm3_pkg::WORD_W-1:0] f2;

  assign item_pop = item_valid && out_space;

  always_comb begin
    base       = started ? running_hash : seed;
    x          = base ^ item.k;
    r          = {x[18:0], x[31:19]};
    hash_next  = (item.nbytes == mm3_pkg::BYTES_PER_WORD) ?
                 ((r << 2) + r + mm3_pkg::HASH_ADD) : x;
    total_next = byte_total + mm3_pkg::WORD_W'(item.nbytes);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started    <= 1'b0;
      byte_total <= '0;
      f0_valid   <= 1'b0;
      f1_valid   <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      f0_valid  <= item_pop && item.last;
      f1_valid  <= f0_valid;
      res_valid <= f1_valid;
      if (item_pop) begin
        started    <= !item.last;
        byte_total <= item.last ? '0 : total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      running_hash <= hash_next;
    end
    // seed length into the hash, then fold high half
    f0 <= (hash_next ^ total_next) ^ ((hash_next ^ total_next) >> 16);
    f1 <= f0 * mm3_pkg::FMIX_C1;
    f2 <= (f1 ^ (f1 >> 13)) * mm3_pkg::FMIX_C2;
  end

  // last fold of the high half
  assign res_hash = f2 ^ (f2 >> 16);

endmodule

[hw/rtl/murmur3_32_hash.sv]
// ----------------------------------------------------------------------------
// murmur3_32_hash
// murmurhash3 x86_32 of a word stream, one hash per message
// ----------------------------------------------------------------------------
// usage:
//   input queue: push a little-endian word with its valid byte count and a
//   last flag while full is low; only the last word may carry fewer than 4
//   bytes, counts above 4 count as 4
//   result queue: while empty is low, hash holds the oldest finished hash;
//   raise pop to take it
//   config: cfg_data is the seed, written when cfg_valid (cfg_ready is
//   always high); write it only while the block is idle, a new seed takes
//   effect with the next message
// timing:
//   one word per cycle while result slots are free; each of the 2 result
//   slots is held from the back taking a last word until its pop, so
//   one-word messages with pop held high stall the back while both are held
//   a last word's hash reaches the result ports through the front's s1 and
//   item registers, the middle queue, f0, f1, f2 and the result queue
// reset: clears all queues and credits, seed returns to zero
// stall: results wait in the output queue; once the output credits are all
//   reserved the back stops taking words, the middle queue fills and full
//   rises, so no request is ever dropped
// ----------------------------------------------------------------------------
module murmur3_32_hash #(
  parameter int QUEUE_DEPTH = 4,
  parameter int OUT_DEPTH   = 2
) (
  input  logic                        clk,
  input  logic                        rst,
  // word request channel
  input  logic                        push,
  output logic                        full,
  input  logic [mm3_pkg::WORD_W-1:0]  data_word,
  input  logic [mm3_pkg::BYTES_W-1:0] valid_bytes,
  input  logic                        last,
  // result channel
  output logic                        empty,
  input  logic                        pop,
  output logic [mm3_pkg::WORD_W-1:0]  hash,
  // seed write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mm3_pkg::WORD_W-1:0]  cfg_data
);

  localparam int IN_CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  logic [mm3_pkg::WORD_W-1:0] seed;
  logic                       take;

  // front to middle queue
  logic                       f_valid;
  mm3_pkg::item_t             f_item;

  // middle queue to back
  mm3_pkg::item_t             q_item;
  logic                       q_empty;
  logic                       q_pop;

  // back to result queue
  logic                       res_valid;
  logic [mm3_pkg::WORD_W-1:0] res_hash;
  logic                       out_take;

  // credits: words in the front pipeline or middle queue, and reserved
  // result slots
  logic [IN_CNT_W-1:0]        in_count;
  logic [OUT_CNT_W-1:0]       out_count;
  logic                       out_space;

  assign cfg_ready = 1'b1;
  assign full      = (in_count == IN_CNT_W'(QUEUE_DEPTH));
  assign take      = push && !full;
  assign out_space = (out_count < OUT_CNT_W'(OUT_DEPTH));
  assign out_take  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed      <= '0;
      in_count  <= '0;
      out_count <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        seed <= cfg_data;
      end
      if (take && !q_pop) begin
        in_count <= in_count + IN_CNT_W'(1);
      end else if (q_pop && !take) begin
        in_count <= in_count - IN_CNT_W'(1);
      end
      // a last word reserves its result slot when the back takes it
      if ((q_pop && q_item.last) && !out_take) begin
        out_count <= out_count + OUT_CNT_W'(1);
      end else if (out_take && !(q_pop && q_item.last)) begin
        out_count <= out_count - OUT_CNT_W'(1);
      end
    end
  end

  mm3_front u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .data_word   (data_word),
    .valid_bytes (valid_bytes),
    .last        (last),
    .item_valid  (f_valid),
    .item        (f_item)
  );

  mm3_fifo #(
    .WIDTH ($bits(mm3_pkg::item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (f_valid),
    .wr_data (f_item),
    .rd_en   (q_pop),
    .rd_data (q_item),
    .empty   (q_empty)
  );

  mm3_back u_back (
    .clk        (clk),
    .rst        (rst),
    .seed       (seed),
    .item_valid (!q_empty),
    .item       (q_item),
    .out_space  (out_space),
    .item_pop   (q_pop),
    .res_valid  (res_valid),
    .res_hash   (res_hash)
  );

  mm3_fifo #(
    .WIDTH (mm3_pkg::WORD_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_valid),
    .wr_data (res_hash),
    .rd_en   (out_take),
    .rd_data (hash),
    .empty   (empty)
  );

`ifndef SYNTHESIS
  // word credits never overrun the middle queue
  a_in_credit: assert property (@(posedge clk) disable iff (rst)
    in_count <= IN_CNT_W'(QUEUE_DEPTH))
    else $error("word credit count above queue depth");

  // result reservations never overrun the output queue
  a_out_credit: assert property (@(posedge clk) disable iff (rst)
    out_count <= OUT_CNT_W'(OUT_DEPTH))
    else $error("result credit count above output depth");

  // back takes a word only when one is queued and a result slot is free
  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (!q_empty && out_space))
    else $error("back took a word without data or result space");

  // a finished hash only comes out of a last word the back took, via f0_valid and f1_valid
  a_res_src: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $past(q_pop && q_item.last, 3))
    else $error("result without a matching last word");
`endif

endmodule
